### design/imhq_pkg.sv
// Package for the indexed max-heap queue: opcodes, status codes, controller states, command and status structs.
// No dependencies.
`default_nettype none
package imhq_pkg;
  localparam int CAPACITY_DEF = 64;
  localparam int VALUE_WIDTH_DEF = 6;
  localparam int PRIORITY_WIDTH_DEF = 16;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_UPDATE = 2'd2,
    OP_NOP    = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_FULL   = 3'd1,
    ST_EMPTY  = 3'd2,
    ST_ABSENT = 3'd3,
    ST_DUP    = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOOKUP,
    S_DECIDE,
    S_UP_RD,
    S_UP_CMP,
    S_DN_RD,
    S_DN_CMP,
    S_ROOT_RD,
    S_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic lookup;
    logic decide;
    logic up_rd;
    logic up_cmp;
    logic dn_rd;
    logic dn_cmp;
    logic root_rd;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic done_now;
    logic go_up;
    logic go_dn;
    logic cont;
  } sts_t;
endpackage
`default_nettype wire

### design/indexed_max_heap_queue_top.sv
// Indexed max-heap queue: one result transaction per input transaction.
// Sequence: a rejected, no-op or emptying transaction skips the sift; a sift passes a read and a
// compare state per level moved, and an update that does not move up then sifts downward.
// Throughput: one transaction in flight; the next is accepted once the result is
// registered; a result held by out_tready stalls only the following result.
// Reset: synchronous active-low rst_n empties the heap and clears the position table.
`default_nettype none
module indexed_max_heap_queue_top #(
  parameter int CAPACITY       = imhq_pkg::CAPACITY_DEF,
  parameter int VALUE_WIDTH    = imhq_pkg::VALUE_WIDTH_DEF,
  parameter int PRIORITY_WIDTH = imhq_pkg::PRIORITY_WIDTH_DEF,
  localparam int CW = $clog2(CAPACITY + 1),
  localparam int IBITS = 2 + VALUE_WIDTH + PRIORITY_WIDTH,
  localparam int OBITS = 3 + 1 + VALUE_WIDTH + PRIORITY_WIDTH + CW + 3
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_tvalid,
  output logic                              in_tready,
  // opcode, item_value, item_priority
  input  wire logic [((IBITS+7)/8)*8-1:0]   in_tdata,
  output logic                              out_tvalid,
  input  wire logic                         out_tready,
  // status, root_valid, root_value, root_priority, entry_count, tree_height
  output logic [((OBITS+7)/8)*8-1:0]        out_tdata
);
  imhq_pkg::cmd_t cmd;
  imhq_pkg::sts_t sts;
  logic busy, start;
  logic [2:0] st;
  logic rvld;
  logic [VALUE_WIDTH-1:0] rv;
  logic signed [PRIORITY_WIDTH-1:0] rp;
  logic [CW-1:0] cnt;
  logic [2:0] ht;
  logic ovalid_r;

  assign in_tready = !busy;
  assign start = in_tvalid && !busy;

  imhq_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .out_free(!ovalid_r),
    .sts(sts), .cmd(cmd), .busy(busy)
  );

  imhq_dp #(.CAPACITY(CAPACITY), .VALUE_WIDTH(VALUE_WIDTH),
    .PRIORITY_WIDTH(PRIORITY_WIDTH)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd),
    .op_in(in_tdata[1:0]),
    .val_in(in_tdata[2 +: VALUE_WIDTH]),
    .pri_in(in_tdata[2+VALUE_WIDTH +: PRIORITY_WIDTH]),
    .sts(sts), .status_o(st), .root_valid_o(rvld), .root_value_o(rv),
    .root_priority_o(rp), .count_o(cnt), .height_o(ht)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) ovalid_r <= 1'b0;
    else if (cmd.finish) ovalid_r <= 1'b1;
    else if (out_tready) ovalid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) out_tdata <= (((OBITS+7)/8)*8)'({ht, cnt, rp, rv, rvld, st});
  end

  assign out_tvalid = ovalid_r;
endmodule
`default_nettype wire

### design/imhq_ctrl.sv
// Controller state machine for the indexed max-heap queue.
// Depends on imhq_pkg.
`default_nettype none
module imhq_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  input  wire logic            out_free,
  input  wire imhq_pkg::sts_t  sts,
  output imhq_pkg::cmd_t       cmd,
  output logic                 busy
);
  imhq_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= imhq_pkg::S_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      imhq_pkg::S_IDLE:    if (start) state_nxt = imhq_pkg::S_LOOKUP;
      imhq_pkg::S_LOOKUP:  state_nxt = imhq_pkg::S_DECIDE;
      imhq_pkg::S_DECIDE: begin
        if (sts.done_now) state_nxt = imhq_pkg::S_ROOT_RD;
        else if (sts.go_up) state_nxt = imhq_pkg::S_UP_RD;
        else state_nxt = imhq_pkg::S_DN_RD;
      end
      imhq_pkg::S_UP_RD:   state_nxt = imhq_pkg::S_UP_CMP;
      imhq_pkg::S_UP_CMP: begin
        if (sts.cont) state_nxt = imhq_pkg::S_UP_RD;
        else if (sts.go_dn) state_nxt = imhq_pkg::S_DN_RD;
        else state_nxt = imhq_pkg::S_ROOT_RD;
      end
      imhq_pkg::S_DN_RD:   state_nxt = imhq_pkg::S_DN_CMP;
      imhq_pkg::S_DN_CMP:  state_nxt = sts.cont ? imhq_pkg::S_DN_RD : imhq_pkg::S_ROOT_RD;
      imhq_pkg::S_ROOT_RD: state_nxt = imhq_pkg::S_DONE;
      imhq_pkg::S_DONE:    if (out_free) state_nxt = imhq_pkg::S_IDLE;
      default:             state_nxt = imhq_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    busy = 1'b1;
    case (state_r)
      imhq_pkg::S_IDLE: begin
        busy = 1'b0;
        cmd.load = start;
      end
      imhq_pkg::S_LOOKUP:  cmd.lookup = 1'b1;
      imhq_pkg::S_DECIDE:  cmd.decide = 1'b1;
      imhq_pkg::S_UP_RD:   cmd.up_rd = 1'b1;
      imhq_pkg::S_UP_CMP:  cmd.up_cmp = 1'b1;
      imhq_pkg::S_DN_RD:   cmd.dn_rd = 1'b1;
      imhq_pkg::S_DN_CMP:  cmd.dn_cmp = 1'b1;
      imhq_pkg::S_ROOT_RD: cmd.root_rd = 1'b1;
      imhq_pkg::S_DONE:    cmd.finish = out_free;
      default:             busy = 1'b1;
    endcase
  end
endmodule
`default_nettype wire

### design/imhq_dp.sv
// Datapath for the indexed max-heap queue: heap memory, position memory, sift unit.
// Depends on imhq_pkg.
`default_nettype none
module imhq_dp #(
  parameter int CAPACITY       = imhq_pkg::CAPACITY_DEF,
  parameter int VALUE_WIDTH    = imhq_pkg::VALUE_WIDTH_DEF,
  parameter int PRIORITY_WIDTH = imhq_pkg::PRIORITY_WIDTH_DEF,
  localparam int IW = $clog2(CAPACITY),
  localparam int CW = $clog2(CAPACITY + 1),
  localparam int VS = 1 << VALUE_WIDTH
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire imhq_pkg::cmd_t                   cmd,
  input  wire logic [1:0]                       op_in,
  input  wire logic [VALUE_WIDTH-1:0]           val_in,
  input  wire logic signed [PRIORITY_WIDTH-1:0] pri_in,
  output imhq_pkg::sts_t                        sts,
  output logic [2:0]                            status_o,
  output logic                                  root_valid_o,
  output logic [VALUE_WIDTH-1:0]                root_value_o,
  output logic signed [PRIORITY_WIDTH-1:0]      root_priority_o,
  output logic [CW-1:0]                         count_o,
  output logic [2:0]                            height_o
);
  logic [VALUE_WIDTH-1:0]           hv_mem [CAPACITY];
  logic signed [PRIORITY_WIDTH-1:0] hp_mem [CAPACITY];
  logic [CW-1:0]                    pos_mem [VS];

  logic [CW-1:0] count_r;
  logic [VS-1:0] pvalid_r;
  logic [1:0] op_r;
  logic [VALUE_WIDTH-1:0] val_r;
  logic signed [PRIORITY_WIDTH-1:0] pri_r;
  logic [2:0] status_r;
  logic [CW-1:0] pos_r;
  logic [IW-1:0] i_r;
  logic moved_r;
  logic [VALUE_WIDTH-1:0] rv_a_r, rv_b_r;
  logic signed [PRIORITY_WIDTH-1:0] rp_a_r, rp_b_r;
  logic [VALUE_WIDTH-1:0] last_v_r;
  logic signed [PRIORITY_WIDTH-1:0] last_p_r;
  logic [VALUE_WIDTH-1:0] root_v_r;
  logic signed [PRIORITY_WIDTH-1:0] root_p_r;
  logic [2:0] height_r;

  // the moving entry lives in (val_r, pri_r); slot i_r is its hole
  logic [CW:0] l_w, r_w;
  logic [IW-1:0] par_w, lidx_w, ridx_w;
  logic has_l, has_r, pick_r;
  logic [VALUE_WIDTH-1:0] c_v;
  logic signed [PRIORITY_WIDTH-1:0] c_p;
  logic [CW-1:0] cnt_m1;
  logic [2:0] h_nxt;

  assign l_w = (CW+1)'({i_r, 1'b1});
  assign r_w = l_w + 1'b1;
  assign par_w = IW'((i_r - 1'b1) >> 1);
  assign lidx_w = l_w[IW-1:0];
  assign ridx_w = r_w[IW-1:0];
  assign has_l = l_w < (CW+1)'(count_r);
  assign has_r = r_w < (CW+1)'(count_r);
  assign pick_r = has_r && (rp_b_r > rp_a_r);
  assign c_v = pick_r ? rv_b_r : rv_a_r;
  assign c_p = pick_r ? rp_b_r : rp_a_r;
  assign cnt_m1 = count_r - 1'b1;

  always_comb begin
    h_nxt = '0;
    for (int k = 1; k < CW; k++) if (count_r[k]) h_nxt = 3'(k);
  end

  always_comb begin
    sts = '0;
    sts.cont = 1'b0;
    if (cmd.up_cmp) sts.cont = (i_r != '0) && (rp_a_r < pri_r);
    if (cmd.dn_cmp) sts.cont = has_l && (pri_r < c_p);
    sts.go_up = (op_r == imhq_pkg::OP_INSERT) || (op_r == imhq_pkg::OP_UPDATE);
    sts.go_dn = cmd.up_cmp ? ((op_r == imhq_pkg::OP_UPDATE) && !moved_r) : !sts.go_up;
    sts.done_now = (status_r != imhq_pkg::ST_OK) || (op_r == imhq_pkg::OP_NOP) ||
                   ((op_r == imhq_pkg::OP_DELETE) && (count_r == '0));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      pvalid_r <= '0;
    end else begin
      if (cmd.lookup) begin
        case (op_r)
          imhq_pkg::OP_INSERT: begin
            if (pos_r != '0) status_r <= imhq_pkg::ST_DUP;
            else if (count_r >= CW'(CAPACITY)) status_r <= imhq_pkg::ST_FULL;
            else begin
              i_r <= IW'(count_r);
              pvalid_r[val_r] <= 1'b1;
              count_r <= count_r + 1'b1;
            end
          end
          imhq_pkg::OP_DELETE: begin
            if (count_r == '0) status_r <= imhq_pkg::ST_EMPTY;
            else begin
              pvalid_r[root_v_r] <= 1'b0;
              count_r <= cnt_m1;
              val_r <= last_v_r;
              pri_r <= last_p_r;
              i_r <= '0;
              if (cnt_m1 == '0) op_r <= imhq_pkg::OP_NOP;
            end
          end
          imhq_pkg::OP_UPDATE: begin
            if (pos_r == '0 || pos_r > count_r) status_r <= imhq_pkg::ST_ABSENT;
            else i_r <= IW'(pos_r - 1'b1);
          end
          default: status_r <= imhq_pkg::ST_OK;
        endcase
      end
      if (cmd.up_cmp && sts.cont) begin
        i_r <= par_w;
        moved_r <= 1'b1;
      end
      if (cmd.dn_cmp && sts.cont) i_r <= pick_r ? ridx_w : lidx_w;
      if (cmd.load) begin
        op_r <= op_in;
        val_r <= val_in;
        pri_r <= pri_in;
        status_r <= imhq_pkg::ST_OK;
        moved_r <= 1'b0;
      end
    end
  end

  // memory reads and writes
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pos_r <= pvalid_r[val_in] ? pos_mem[val_in] : '0;
      last_v_r <= hv_mem[IW'(count_r - 1'b1)];
      last_p_r <= hp_mem[IW'(count_r - 1'b1)];
    end
    if (cmd.decide || cmd.up_rd || cmd.dn_rd) begin
      if (cmd.dn_rd || (cmd.decide && sts.go_dn)) begin
        rv_a_r <= hv_mem[lidx_w]; rp_a_r <= hp_mem[lidx_w];
        rv_b_r <= hv_mem[ridx_w]; rp_b_r <= hp_mem[ridx_w];
      end else begin
        rv_a_r <= hv_mem[par_w]; rp_a_r <= hp_mem[par_w];
      end
    end
    if (cmd.decide && !sts.done_now) begin
      hv_mem[i_r] <= val_r; hp_mem[i_r] <= pri_r;
      pos_mem[val_r] <= CW'(i_r) + 1'b1;
    end
    if (cmd.up_cmp && sts.cont) begin
      hv_mem[i_r] <= rv_a_r; hp_mem[i_r] <= rp_a_r;
      pos_mem[rv_a_r] <= CW'(i_r) + 1'b1;
      hv_mem[par_w] <= val_r; hp_mem[par_w] <= pri_r;
    end
    if (cmd.dn_cmp && sts.cont) begin
      hv_mem[i_r] <= c_v; hp_mem[i_r] <= c_p;
      pos_mem[c_v] <= CW'(i_r) + 1'b1;
    end
    if ((cmd.up_cmp || cmd.dn_cmp) && !sts.cont) begin
      hv_mem[i_r] <= val_r; hp_mem[i_r] <= pri_r;
      pos_mem[val_r] <= CW'(i_r) + 1'b1;
    end
    if (cmd.root_rd) begin
      height_r <= h_nxt;
    end
    if (cmd.load) begin
      root_v_r <= hv_mem['0];
      root_p_r <= hp_mem['0];
    end
    if (cmd.decide || (cmd.up_cmp && sts.cont)) begin
      if (cmd.up_cmp && par_w == '0) begin
        root_v_r <= val_r; root_p_r <= pri_r;
      end
    end
    if (cmd.root_rd) begin
      root_v_r <= hv_mem['0];
      root_p_r <= hp_mem['0];
    end
  end

  assign status_o = status_r;
  assign root_valid_o = count_r != '0;
  assign root_value_o = (count_r != '0) ? root_v_r : '0;
  assign root_priority_o = (count_r != '0) ? root_p_r : '0;
  assign count_o = count_r;
  assign height_o = height_r;
endmodule
`default_nettype wire
